// ===== rtl/tth_pkg.sv =====
// ---------------------------------------------------------------------------
// tth_pkg
// Types and constants shared by the token hash unit modules.
// ---------------------------------------------------------------------------
package tth_pkg;

   localparam int QUEUE_DEPTH = 4;

   // register indexes on the csr port
   localparam logic CSR_SEED_KEY = 1'b0;
   localparam logic CSR_MIX_KEY  = 1'b1;

   localparam int HASH_WIDTH  = 32;
   localparam int VALUE_WIDTH = 20;

   // v mod 1000000: 1000000 = 2^6 * 15625, so q = ((v >> 6) * RECIP) >> 40
   // is exact for every 32-bit v (26-bit operand, 27-bit reciprocal).
   localparam logic [19:0] MODULUS     = 20'd1000000;
   localparam int          POW2_SHIFT  = 6;
   localparam int          RECIP_SHIFT = 40;
   localparam logic [26:0] RECIP       = 27'd70368745;
   localparam int          QUOT_WIDTH  = 13;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       byte_valid;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] token_value;
      logic [HASH_WIDTH-1:0]  token_check;
   } rsp_type;

   // finished message hash waiting for the final mix and reduction
   typedef struct packed {
      logic [HASH_WIDTH-1:0] hash;
      logic [HASH_WIDTH-1:0] mix_key;
      logic [HASH_WIDTH-1:0] seed_key;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;

   typedef struct packed {
      logic    avail;
      job_type job;
   } head_type;

   function automatic logic [HASH_WIDTH-1:0] byte_round(
      input logic [HASH_WIDTH-1:0] h,
      input logic [7:0]            b
   );
      logic [HASH_WIDTH-1:0] a;
      logic [HASH_WIDTH-1:0] m;
      a = h + {{(HASH_WIDTH-8){1'b0}}, b};
      m = a + (a << 10);
      return m ^ (m >> 6);
   endfunction

endpackage

// ===== rtl/translate_token_hash_unit.sv =====
// ---------------------------------------------------------------------------
// translate_token_hash_unit
// Running 32-bit byte hash with keyed final mix and modulo 1000000 token.
// ---------------------------------------------------------------------------
// Takes one message byte per clock while req_stall is low. The front folds each
// byte into the running hash register; an item flagged last_byte puts the finished
// hash into a short queue (QUEUE_DEPTH entries) and the front is free for the next
// message straight away. The back drains the queue at one message per cycle while
// rsp_stall does not hold the output register, through four stages (two mix stages,
// reciprocal multiply, remainder and check into the output register). req_stall
// rises only when the queue is full, i.e. when QUEUE_DEPTH tokens back up behind
// rsp_stall. Keys are written through the csr port, index 0 seed_key, index 1
// mix_key, and are always ready.
module translate_token_hash_unit #(
   parameter int QUEUE_DEPTH = tth_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tth_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tth_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [31:0]      csr_data
);

   tth_pkg::push_type push;
   tth_pkg::head_type head;
   logic              queue_full;
   logic              pop;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;

   tth_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .queue_full (queue_full),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push_out   (push)
   );

   tth_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_in  (push),
      .pop      (pop),
      .full     (queue_full),
      .head_out (head)
   );

   tth_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_in   (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/tth_front.sv =====
// ---------------------------------------------------------------------------
// tth_front
// Key registers and per-byte running hash; hands finished messages on.
// ---------------------------------------------------------------------------
module tth_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  tth_pkg::req_type  req_data,
   input  logic              queue_full,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [31:0]       csr_data,
   output tth_pkg::push_type push_out
);

   logic [31:0] seed_key_ff, seed_key_in;
   logic [31:0] mix_key_ff, mix_key_in;
   logic [31:0] hash_ff, hash_in;
   logic        in_message_ff, in_message_in;
   logic        accept;
   logic [31:0] base;
   logic [31:0] next_hash;

   assign accept = req_valid && !queue_full;

   always_comb begin
      seed_key_in = seed_key_ff;
      mix_key_in  = mix_key_ff;
      if (csr_write) begin
         case (csr_index)
            tth_pkg::CSR_SEED_KEY: seed_key_in = csr_data;
            tth_pkg::CSR_MIX_KEY:  mix_key_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      // first item of a message starts from the seed
      base      = in_message_ff ? hash_ff : seed_key_ff;
      next_hash = req_data.byte_valid ? tth_pkg::byte_round(base, req_data.text_byte) : base;

      hash_in       = hash_ff;
      in_message_in = in_message_ff;
      if (accept) begin
         hash_in       = next_hash;
         in_message_in = !req_data.last_byte;
      end

      push_out.push          = accept && req_data.last_byte;
      push_out.job.hash      = next_hash;
      push_out.job.mix_key   = mix_key_ff;
      push_out.job.seed_key  = seed_key_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_key_ff   <= '0;
         mix_key_ff    <= '0;
         hash_ff       <= '0;
         in_message_ff <= 1'b0;
      end else begin
         seed_key_ff   <= seed_key_in;
         mix_key_ff    <= mix_key_in;
         hash_ff       <= hash_in;
         in_message_ff <= in_message_in;
      end
   end

endmodule

// ===== rtl/tth_queue.sv =====
// ---------------------------------------------------------------------------
// tth_queue
// Short queue of finished message hashes between front and back.
// ---------------------------------------------------------------------------
module tth_queue #(
   parameter int DEPTH = tth_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  tth_pkg::push_type push_in,
   input  logic              pop,
   output logic              full,
   output tth_pkg::head_type head_out
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   tth_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full           = (count_ff == CNT_W'(DEPTH));
   assign head_out.avail = (count_ff != '0);
   assign head_out.job   = entry_ff[rd_ptr_ff];
   assign do_push        = push_in.push && !full;
   assign do_pop         = pop && head_out.avail;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_in.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/tth_back.sv =====
// ---------------------------------------------------------------------------
// tth_back
// Final mix, key XOR and modulo reduction, four pipeline stages.
// ---------------------------------------------------------------------------
module tth_back (
   input  logic              clock,
   input  logic              reset,
   input  tth_pkg::head_type head_in,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tth_pkg::rsp_type  rsp_data
);

   localparam int PROD_W = 26 + 27;

   logic        pipe_en;

   logic        s1_valid_ff;
   logic [31:0] s1_hash_ff, s1_hash_in;
   logic [31:0] s1_mix_ff;
   logic [31:0] s1_seed_ff;

   logic        s2_valid_ff;
   logic [31:0] s2_value_ff, s2_value_in;
   logic [31:0] s2_seed_ff;

   logic        s3_valid_ff;
   logic [tth_pkg::QUOT_WIDTH-1:0] s3_quot_ff, s3_quot_in;
   logic [31:0] s3_value_ff;
   logic [31:0] s3_seed_ff;

   logic             out_valid_ff;
   tth_pkg::rsp_type out_data_ff, out_data_in;

   logic [31:0]       mix_a;
   logic [31:0]       mix_c;
   logic [PROD_W-1:0] recip_prod;
   logic [32:0]       back_prod;
   logic [31:0]       remainder;

   // whole pipe moves together whenever the output register can take an item
   assign pipe_en   = !out_valid_ff || !rsp_stall;
   assign pop       = pipe_en && head_in.avail;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      mix_a       = head_in.job.hash + (head_in.job.hash << 3);
      s1_hash_in  = mix_a ^ (mix_a >> 11);

      mix_c       = s1_hash_ff + (s1_hash_ff << 15);
      s2_value_in = mix_c ^ s1_mix_ff;

      recip_prod  = PROD_W'(s2_value_ff[31:tth_pkg::POW2_SHIFT]) * PROD_W'(tth_pkg::RECIP);
      s3_quot_in  = recip_prod[tth_pkg::RECIP_SHIFT +: tth_pkg::QUOT_WIDTH];

      back_prod   = 33'(s3_quot_ff) * 33'(tth_pkg::MODULUS);
      remainder   = s3_value_ff - back_prod[31:0];
      out_data_in.token_value = remainder[tth_pkg::VALUE_WIDTH-1:0];
      out_data_in.token_check = {{(32-tth_pkg::VALUE_WIDTH){1'b0}},
                                 remainder[tth_pkg::VALUE_WIDTH-1:0]} ^ s3_seed_ff;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_hash_ff  <= s1_hash_in;
         s1_mix_ff   <= head_in.job.mix_key;
         s1_seed_ff  <= head_in.job.seed_key;
         s2_value_ff <= s2_value_in;
         s2_seed_ff  <= s1_seed_ff;
         s3_quot_ff  <= s3_quot_in;
         s3_value_ff <= s2_value_ff;
         s3_seed_ff  <= s2_seed_ff;
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff  <= head_in.avail;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

endmodule

// ===== test/token_hash_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// token_hash_checker
// Watches the item, result and key-write channels of the token hash unit,
// predicts every token from the accepted items and compares it with the
// result channel in arrival order.
// ---------------------------------------------------------------------------
module token_hash_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  tth_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  tth_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic             csr_index,
   input  logic [31:0]      csr_data,
   output int               errors,
   output int               pending
);

   localparam logic [31:0] TOKEN_MOD = 32'd1000000;

   logic [31:0]      seed_key_q;
   logic [31:0]      mix_key_q;
   logic [31:0]      msg_hash;
   logic             msg_open;
   tth_pkg::rsp_type token_queue[$];

   initial errors = 0;
   initial pending = 0;

   function automatic logic [31:0] fold_byte(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] s;
      s = h + {24'd0, b};
      s = s + (s << 10);
      return s ^ (s >> 6);
   endfunction

   // final avalanche, key mix and reduction to the six-digit token
   function automatic logic [31:0] token_of(input logic [31:0] h, input logic [31:0] k);
      logic [31:0] t;
      t = h + (h << 3);
      t = t ^ (t >> 11);
      t = t + (t << 15);
      t = t ^ k;
      return t % TOKEN_MOD;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      logic [31:0]      v;
      tth_pkg::rsp_type want;
      if (reset) begin
         seed_key_q = '0;
         mix_key_q  = '0;
         msg_hash   = '0;
         msg_open   = 1'b0;
         token_queue.delete();
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tth_pkg::CSR_SEED_KEY: seed_key_q = csr_data;
               tth_pkg::CSR_MIX_KEY:  mix_key_q  = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (!msg_open) begin
               msg_hash = seed_key_q;
               msg_open = 1'b1;
            end
            if (req_data.byte_valid)
               msg_hash = fold_byte(msg_hash, req_data.text_byte);
            if (req_data.last_byte) begin
               v = token_of(msg_hash, mix_key_q);
               want.token_value = v[19:0];
               want.token_check = v ^ seed_key_q;
               token_queue.push_back(want);
               msg_open = 1'b0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (token_queue.size() == 0) begin
               report_mismatch("unexpected result", {12'd0, rsp_data.token_value},
                               rsp_data.token_check);
            end else begin
               want = token_queue.pop_front();
               if (rsp_data.token_value !== want.token_value)
                  report_mismatch("token_value", {12'd0, rsp_data.token_value},
                                  {12'd0, want.token_value});
               if (rsp_data.token_check !== want.token_check)
                  report_mismatch("token_check", rsp_data.token_check, want.token_check);
            end
         end
         pending <= token_queue.size();
      end
   end

endmodule

// ===== test/tb_translate_token_hash_unit.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_translate_token_hash_unit
// Stimulus and verdict for the token hash unit.
// ---------------------------------------------------------------------------
// A short directed run covers empty messages, invalid bytes inside and at the
// end of a message, key extremes and key writes in the middle of a message;
// then phases of random messages and noise under fresh keys follow. Both
// channels idle at random except for one quiet phase. The checker beside the
// unit predicts and compares every token.
module tb_translate_token_hash_unit;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   tth_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   tth_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic             csr_index = tth_pkg::CSR_SEED_KEY;
   logic [31:0]      csr_data  = '0;

   int          errors;
   int          pending;
   int          sent  = 0;
   bit          quiet = 1'b0;

   translate_token_hash_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   token_hash_checker chk (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .errors    (errors),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 26);
   end

   task automatic send_item(input logic [7:0] b, input logic v, input logic l);
      tth_pkg::req_type item;
      item.text_byte  = b;
      item.byte_valid = v;
      item.last_byte  = l;
      while (!quiet && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   // len 0 gives an empty message; about one byte in ten is marked invalid
   task automatic send_message(input int unsigned len);
      if (len == 0) begin
         send_item(8'($urandom), 1'b0, 1'b1);
      end else begin
         for (int unsigned i = 1; i <= len; i++)
            send_item(8'($urandom), $urandom_range(9) != 0, i == len);
      end
   endtask

   // keys may only change once every token has come out and the unit has settled
   task automatic wait_idle();
      req_valid <= 1'b0;
      // let pending catch up so that the count includes a token accepted at the last edge
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_keys(input logic [31:0] seed, input logic [31:0] mix);
      csr_valid <= 1'b1;
      csr_index <= tth_pkg::CSR_SEED_KEY;
      csr_data  <= seed;
      do @(posedge clock); while (!csr_ready);
      csr_index <= tth_pkg::CSR_MIX_KEY;
      csr_data  <= mix;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      int unsigned r;
      r = $urandom_range(4);
      if (r == 0) return 32'h0000_0000;
      if (r == 1) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   initial begin
      int unsigned goal;
      int unsigned r;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // keys still at reset value
      send_item(8'h00, 1'b0, 1'b1);
      wait_idle();
      write_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'hAA, 1'b0, 1'b0);
      send_item(8'h80, 1'b1, 1'b1);
      send_item(8'h55, 1'b1, 1'b0);
      send_item(8'h3C, 1'b0, 1'b1);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h11, 1'b1, 1'b1);
      send_item(8'h7F, 1'b0, 1'b1);
      wait_idle();
      write_keys(32'h1234_5678, 32'h0000_0000);
      // message left open across a key change
      send_item(8'h01, 1'b1, 1'b0);
      send_item(8'h7E, 1'b1, 1'b0);
      wait_idle();
      write_keys(32'hDEAD_BEEF, 32'hA5A5_A5A5);
      send_item(8'hC3, 1'b1, 1'b1);
      send_item(8'h5A, 1'b1, 1'b1);

      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         quiet = (ph == 3);
         write_keys(pick_key(), pick_key());
         goal = sent + 155;
         while (sent < goal) begin
            r = $urandom_range(99);
            if (r < 8)
               send_item(8'($urandom), 1'($urandom), 1'($urandom));
            else if (r < 14)
               send_message(0);
            else if (r < 18)
               send_message($urandom_range(48, 20));
            else
               send_message($urandom_range(8, 1));
         end
         if ($urandom_range(1)) begin
            r = $urandom_range(3, 1);
            repeat (r) send_item(8'($urandom), 1'($urandom), 1'b0);
         end
      end
      quiet = 1'b0;

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #400000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
